FILE: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the status frame receiver: transaction
// payloads, configuration register map, timer and frame sizes.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int FRAME_BYTES = 18;
   localparam int TIMER_BITS  = 16;
   localparam int INDEX_BITS  = $clog2(FRAME_BYTES + 1);

   // Configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [15:0] INTERBYTE_RESET = 16'd50;
   localparam logic [15:0] FRAME_TO_RESET  = 16'd300;
   localparam logic [7:0]  START_RESET     = 8'h7F;

   typedef enum logic [1:0] {
      REG_INTERBYTE = 2'd0,
      REG_FRAME_TO  = 2'd1,
      REG_START     = 2'd2
   } sfr_reg_type;

   // Input operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result event codes
   localparam logic EVT_FRAME_OK  = 1'b0;
   localparam logic EVT_CHECKSUM  = 1'b1;

   // Byte positions inside the frame
   localparam int POS_VERSION = 1;
   localparam int POS_MACHINE = 2;
   localparam int POS_FAULT   = 3;
   localparam int POS_GATE    = 4;
   localparam int POS_ALARM   = 5;
   localparam int POS_LEFT    = 6;
   localparam int POS_RIGHT   = 9;
   localparam int POS_IR      = 12;
   localparam int POS_CMD     = 13;
   localparam int POS_SUPPLY  = 14;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } sfr_req_type;

   typedef struct packed {
      logic        frame_event;
      logic [7:0]  version;
      logic [7:0]  unit_number;
      logic [7:0]  fault_code;
      logic [7:0]  gate_state;
      logic [7:0]  alarm_code;
      logic [23:0] left_passages;
      logic [23:0] right_passages;
      logic [7:0]  infrared_state;
      logic [7:0]  command_result;
      logic [7:0]  supply_voltage;
   } sfr_rsp_type;

   typedef struct packed {
      logic [15:0] gap_limit;
      logic [15:0] age_limit;
      logic [7:0]  start_byte;
   } sfr_cfg_type;

   typedef struct packed {
      logic        valid;
      sfr_rsp_type data;
   } sfr_result_type;

endpackage

FILE: rtl/status_frame_receiver.sv
// ----------------------------------------------------------------------------
// status_frame_receiver
// Start-byte framed, fixed-length status frame receiver with sum checksum.
// ----------------------------------------------------------------------------
// Takes one transaction per clock: a received byte or a 1 ms tick. A request
// is captured in an input register and is processed by the frame tracker
// once the result register can take a result; any decoded frame (or checksum
// error) lands in the result register at the end of that cycle and raises
// rsp_valid. Throughput is one transaction per cycle; it drops only while
// the result register holds an untaken result, which stalls the input
// register. Frames are 18 bytes opened by the start byte; the 8-bit sum of
// all bytes plus one must be zero. Timeouts are counted in ticks. Configure
// only while idle.
// ----------------------------------------------------------------------------
module status_frame_receiver import sfr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sfr_req_type              req_data,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sfr_rsp_type              rsp_data,
   // configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   sfr_cfg_type    cfg;
   sfr_result_type result;

   // input register
   logic        in_valid_ff, in_valid_in;
   sfr_req_type in_data_ff;
   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   sfr_rsp_type rsp_data_ff;

   logic advance;   // input register hands its transaction to the tracker
   logic load_rsp;

   // The tracker steps whenever the input register holds a transaction and the result register can take a result.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign load_rsp  = advance && result.valid;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfr_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_data_ff <= result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled input transaction lost or changed");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input accepted while pipeline is blocked");
`endif

endmodule

FILE: rtl/sfr_csr.sv
// ----------------------------------------------------------------------------
// sfr_csr
// Configuration registers behind an APB-style port: timeouts and start byte.
// ----------------------------------------------------------------------------
module sfr_csr import sfr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output sfr_cfg_type              cfg
);

   sfr_cfg_type cfg_ff;
   sfr_cfg_type cfg_in;
   sfr_reg_type reg_sel;
   logic        write_en;

   assign reg_sel    = sfr_reg_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_sel)
            REG_INTERBYTE: cfg_in.gap_limit  = csr_pwdata[15:0];
            REG_FRAME_TO:  cfg_in.age_limit  = csr_pwdata[15:0];
            REG_START:     cfg_in.start_byte = csr_pwdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_INTERBYTE: csr_prdata = {16'd0, cfg_ff.gap_limit};
         REG_FRAME_TO:  csr_prdata = {16'd0, cfg_ff.age_limit};
         REG_START:     csr_prdata = {24'd0, cfg_ff.start_byte};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_limit  <= INTERBYTE_RESET;
         cfg_ff.age_limit  <= FRAME_TO_RESET;
         cfg_ff.start_byte <= START_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/sfr_frame.sv
// ----------------------------------------------------------------------------
// sfr_frame
// Frame tracker: start detection, tick timers, byte store, running sum and
// decode of a completed frame. One transaction is processed per step.
// ----------------------------------------------------------------------------
module sfr_frame import sfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  sfr_req_type    item,
   input  sfr_cfg_type    cfg,
   output sfr_result_type result
);

   localparam logic [TIMER_BITS-1:0] TimerMax = '1;
   localparam logic [INDEX_BITS-1:0] LastIndex = INDEX_BITS'(FRAME_BYTES - 1);

   logic [7:0]            store_ff [FRAME_BYTES];
   logic                  in_frame_ff, in_frame_in;
   logic [INDEX_BITS-1:0] byte_index_ff, byte_index_in;
   logic [TIMER_BITS-1:0] since_last_ff, since_last_in;
   logic [TIMER_BITS-1:0] since_start_ff, since_start_in;
   logic [7:0]            sum_ff, sum_in;

   logic                  is_byte;
   logic                  gap_expired;
   logic                  live;
   logic                  frame_expired;
   logic                  store_we;
   logic [INDEX_BITS-1:0] store_idx;
   logic [7:0]            sum_next;
   logic                  checksum_ok;

   assign is_byte       = step && (item.operation == OP_BYTE);
   assign gap_expired   = in_frame_ff && (32'(since_last_ff) > 32'(cfg.gap_limit));
   assign live          = in_frame_ff && !gap_expired;
   assign frame_expired = 32'(since_start_ff) > 32'(cfg.age_limit);
   assign sum_next      = sum_ff + item.rx_byte;
   assign checksum_ok   = (sum_next + 8'd1) == 8'd0;

   always_comb begin
      in_frame_in    = in_frame_ff;
      byte_index_in  = byte_index_ff;
      since_last_in  = since_last_ff;
      since_start_in = since_start_ff;
      sum_in         = sum_ff;
      store_we       = 1'b0;
      store_idx      = byte_index_ff;
      result         = '0;
      if (step && (item.operation == OP_TICK)) begin
         if (in_frame_ff) begin
            since_last_in  = (since_last_ff == TimerMax) ? TimerMax : since_last_ff + 1'b1;
            since_start_in = (since_start_ff == TimerMax) ? TimerMax : since_start_ff + 1'b1;
         end
      end else if (is_byte && !live) begin
         // Idle, or the gap timer ran out: this byte may open a new frame.
         if (item.rx_byte == cfg.start_byte) begin
            in_frame_in    = 1'b1;
            since_last_in  = '0;
            since_start_in = '0;
            byte_index_in  = INDEX_BITS'(1);
            sum_in         = item.rx_byte;
            store_we       = 1'b1;
            store_idx      = '0;
         end else if (gap_expired) begin
            in_frame_in   = 1'b0;
            byte_index_in = '0;
         end
      end else if (is_byte) begin
         store_we      = 1'b1;
         byte_index_in = byte_index_ff + 1'b1;
         sum_in        = sum_next;
         since_last_in = '0;
         if (frame_expired) begin
            in_frame_in   = 1'b0;
            byte_index_in = '0;
         end else if (byte_index_ff == LastIndex) begin
            in_frame_in   = 1'b0;
            byte_index_in = '0;
            result.valid  = 1'b1;
            if (checksum_ok) begin
               result.data.frame_event    = EVT_FRAME_OK;
               result.data.version        = store_ff[POS_VERSION];
               result.data.unit_number    = store_ff[POS_MACHINE];
               result.data.fault_code     = store_ff[POS_FAULT];
               result.data.gate_state     = store_ff[POS_GATE];
               result.data.alarm_code     = store_ff[POS_ALARM];
               result.data.left_passages  = {store_ff[POS_LEFT], store_ff[POS_LEFT+1],
                                             store_ff[POS_LEFT+2]};
               result.data.right_passages = {store_ff[POS_RIGHT], store_ff[POS_RIGHT+1],
                                             store_ff[POS_RIGHT+2]};
               result.data.infrared_state = store_ff[POS_IR];
               result.data.command_result = store_ff[POS_CMD];
               result.data.supply_voltage = store_ff[POS_SUPPLY];
            end else begin
               result.data.frame_event = EVT_CHECKSUM;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= item.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         byte_index_ff  <= '0;
         since_last_ff  <= '0;
         since_start_ff <= '0;
         sum_ff         <= '0;
      end else begin
         in_frame_ff    <= in_frame_in;
         byte_index_ff  <= byte_index_in;
         since_last_ff  <= since_last_in;
         since_start_ff <= since_start_in;
         sum_ff         <= sum_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_index_zero: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> byte_index_ff == '0)
      else $error("byte index not cleared outside a frame");

   a_result_at_last_byte: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> in_frame_ff && byte_index_ff == LastIndex && is_byte)
      else $error("result raised away from the last frame byte");
`endif

endmodule

FILE: bench/status_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_frame_receiver_test
// Self-checking bench for the start-byte framed status frame receiver.
// A scripted opening walks reset values, field extremes, checksum errors,
// timeouts and start bytes inside a frame. Random frame traffic follows under
// several register settings and idle/stall mixes. Every result transaction is
// compared field by field against an in-bench frame tracker or a scripted report.
// ----------------------------------------------------------------------------
module status_frame_receiver_test import sfr_pkg::*;;

   localparam int SEGMENT_ITEMS = 130;       // counted frame items per random segment
   localparam int SETTLE_CYCLES = 8;         // block holds a transaction in its input and result registers
   localparam int WATCHDOG_NS   = 10_000_000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RSP_BITS      = $bits(sfr_rsp_type);

   localparam logic [CSR_ADDR_BITS-1:0] UNMAPPED_ADDR = CSR_ADDR_BITS'(12);

   // Reports that can be read straight off the frame layout
   localparam sfr_rsp_type CHECKSUM_REPORT = {EVT_CHECKSUM, {(RSP_BITS-1){1'b0}}};
   localparam sfr_rsp_type ALL_ONES_REPORT = {EVT_FRAME_OK, {(RSP_BITS-1){1'b1}}};
   localparam sfr_rsp_type ALL_ZERO_REPORT = {EVT_FRAME_OK, {(RSP_BITS-1){1'b0}}};

   // One line of the opening script: `count` copies of an item, each preceded
   // by `gap` ticks. fix_sum replaces the byte with the closing checksum.
   typedef struct packed {
      logic        op;
      logic [7:0]  data;
      logic [7:0]  count;
      logic [15:0] gap;
      logic        fix_sum;
      logic        has_typed;
      sfr_rsp_type typed;
   } script_line_type;

   // ---------------------------------------------------------------------
   // DUT connections, all inputs known from time zero
   // ---------------------------------------------------------------------
   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   sfr_req_type              req_data    = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b1;
   sfr_rsp_type              rsp_data;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   status_frame_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Frame tracker: bench-side copy of registers and frame state
   // ---------------------------------------------------------------------
   logic [15:0]           ib_limit  = INTERBYTE_RESET;
   logic [15:0]           ft_limit  = FRAME_TO_RESET;
   logic [7:0]            sof_byte  = START_RESET;
   logic [7:0]            frame_buf [FRAME_BYTES];
   bit                    in_frame  = 1'b0;
   int                    byte_pos  = 0;
   logic [TIMER_BITS-1:0] since_byte  = '0;
   logic [TIMER_BITS-1:0] since_start = '0;
   logic [7:0]            frame_sum = '0;

   sfr_rsp_type     frame_reports[$];   // reports owed by the DUT, oldest first
   script_line_type script[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int reports_seen   = 0;
   int items_accepted = 0;
   int noise_items    = 0;
   int configs_written = 0;

   task automatic note_error(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Advance the tracker by one accepted request; got=1 when a frame closes.
   task automatic track_frame(input sfr_req_type item, output bit got,
                              output sfr_rsp_type rep);
      logic [7:0] b;
      b   = item.rx_byte;
      got = 1'b0;
      rep = '0;
      if (item.operation == OP_TICK) begin
         // ticks only count while a frame is open; counters saturate
         if (in_frame) begin
            if (since_byte != '1) since_byte++;
            if (since_start != '1) since_start++;
         end
         return;
      end
      // inter-byte timeout: drop, then treat this byte as if idle
      if (in_frame && since_byte > ib_limit) begin
         in_frame = 1'b0;
         byte_pos = 0;
      end
      if (!in_frame) begin
         if (b == sof_byte) begin
            in_frame    = 1'b1;
            since_byte  = '0;
            since_start = '0;
            frame_buf[0] = b;
            byte_pos    = 1;
            frame_sum   = b;
         end
         return;
      end
      frame_buf[byte_pos] = b;
      byte_pos++;
      frame_sum  = frame_sum + b;
      since_byte = '0;
      // frame timeout swallows the byte, even a closing one
      if (since_start > ft_limit) begin
         in_frame = 1'b0;
         byte_pos = 0;
         return;
      end
      if (byte_pos < FRAME_BYTES) return;
      in_frame = 1'b0;
      byte_pos = 0;
      got      = 1'b1;
      // sum + 1 == 0 (mod 256) means the sum is all ones
      if (frame_sum != 8'hFF) begin
         rep.frame_event = EVT_CHECKSUM;
         return;
      end
      rep.frame_event    = EVT_FRAME_OK;
      rep.version        = frame_buf[POS_VERSION];
      rep.unit_number    = frame_buf[POS_MACHINE];
      rep.fault_code     = frame_buf[POS_FAULT];
      rep.gate_state     = frame_buf[POS_GATE];
      rep.alarm_code     = frame_buf[POS_ALARM];
      rep.left_passages  = {frame_buf[POS_LEFT], frame_buf[POS_LEFT+1],
                            frame_buf[POS_LEFT+2]};
      rep.right_passages = {frame_buf[POS_RIGHT], frame_buf[POS_RIGHT+1],
                            frame_buf[POS_RIGHT+2]};
      rep.infrared_state = frame_buf[POS_IR];
      rep.command_result = frame_buf[POS_CMD];
      rep.supply_voltage = frame_buf[POS_SUPPLY];
   endtask

   function automatic logic [31:0] reg_image(input sfr_reg_type r);
      case (r)
         REG_INTERBYTE: return {16'h0, ib_limit};
         REG_FRAME_TO:  return {16'h0, ft_limit};
         REG_START:     return {24'h0, sof_byte};
         default:       return '0;
      endcase
   endfunction

   task automatic apply_register(input logic [CSR_ADDR_BITS-1:0] addr,
                                 input logic [31:0] value);
      case (sfr_reg_type'(addr[CSR_ADDR_BITS-1:2]))
         REG_INTERBYTE: ib_limit = value[15:0];
         REG_FRAME_TO:  ft_limit = value[15:0];
         REG_START:     sof_byte = value[7:0];
         default: ;     // unmapped, ignored
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Result monitor: sampled at the rising edge, inputs move at the falling
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      sfr_rsp_type want;
      string bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_reports.size() == 0) begin
            note_error($sformatf("result transaction with nothing owed: %h", rsp_data));
         end else begin
            want = frame_reports.pop_front();
            bad  = "";
            if (rsp_data.frame_event    !== want.frame_event)    bad = {bad, " frame_event"};
            if (rsp_data.version        !== want.version)        bad = {bad, " version"};
            if (rsp_data.unit_number    !== want.unit_number)    bad = {bad, " unit_number"};
            if (rsp_data.fault_code     !== want.fault_code)     bad = {bad, " fault_code"};
            if (rsp_data.gate_state     !== want.gate_state)     bad = {bad, " gate_state"};
            if (rsp_data.alarm_code     !== want.alarm_code)     bad = {bad, " alarm_code"};
            if (rsp_data.left_passages  !== want.left_passages)  bad = {bad, " left_passages"};
            if (rsp_data.right_passages !== want.right_passages) bad = {bad, " right_passages"};
            if (rsp_data.infrared_state !== want.infrared_state) bad = {bad, " infrared_state"};
            if (rsp_data.command_result !== want.command_result) bad = {bad, " command_result"};
            if (rsp_data.supply_voltage !== want.supply_voltage) bad = {bad, " supply_voltage"};
            if (bad != "")
               note_error($sformatf("report %0d wrong in%s: want %h got %h",
                                    reports_seen, bad, want, rsp_data));
         end
         reports_seen++;
      end
   end

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_ready = (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Request driver. Called at a falling edge, returns at a falling edge
   // with valid still high; the next call either idles or presents new data.
   // ---------------------------------------------------------------------
   task automatic send_item(input sfr_req_type item, input bit use_typed,
                            input sfr_rsp_type typed);
      bit got;
      sfr_rsp_type rep;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      track_frame(item, got, rep);
      // a typed row result replaces the tracker's value for the DUT check
      if (got || use_typed) frame_reports.push_back(use_typed ? typed : rep);
      items_accepted++;
      @(negedge clock);
   endtask

   function automatic sfr_req_type tick_item();
      sfr_req_type t;
      t.operation = OP_TICK;
      t.rx_byte   = 8'($urandom);   // ignored by the block, toggled anyway
      return t;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      sfr_req_type t;
      t.operation = OP_BYTE;
      t.rx_byte   = b;
      send_item(t, 1'b0, '0);
   endtask

   // Wait for all owed reports plus the pipeline depth; block is then idle.
   task automatic settle();
      req_valid = 1'b0;
      while (frame_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_register(addr, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic verify_register(input sfr_reg_type r);
      logic [31:0] got;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {r, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (got !== reg_image(r))
         note_error($sformatf("register %s reads %h, want %h", r.name(), got, reg_image(r)));
   endtask

   // Upper bits carry junk that the block must mask off
   task automatic program_register(input sfr_reg_type r, input logic [31:0] value,
                                   input logic [31:0] mask);
      csr_write({r, 2'b00}, (value & mask) | ($urandom & ~mask));
      verify_register(r);
      configs_written++;
   endtask

   task automatic set_registers(input logic [15:0] ib, input logic [15:0] ft,
                                input logic [7:0] sof);
      settle();
      program_register(REG_INTERBYTE, {16'h0, ib}, 32'h0000_FFFF);
      program_register(REG_FRAME_TO, {16'h0, ft}, 32'h0000_FFFF);
      program_register(REG_START, {24'h0, sof}, 32'h0000_00FF);
   endtask

   // ---------------------------------------------------------------------
   // Scripted stimulus
   // ---------------------------------------------------------------------
   task automatic add_line(input logic op, input logic [7:0] data, input int count,
                           input int gap = 0, input bit fix_sum = 1'b0,
                           input bit has_typed = 1'b0, input sfr_rsp_type typed = '0);
      script_line_type l;
      l.op = op;  l.data = data;  l.count = 8'(count);  l.gap = 16'(gap);
      l.fix_sum = fix_sum;  l.has_typed = has_typed;  l.typed = typed;
      script.push_back(l);
   endtask

   task automatic play_script();
      script_line_type l;
      sfr_req_type item;
      foreach (script[i]) begin
         l = script[i];
         for (int n = 0; n < int'(l.count); n++) begin
            repeat (l.gap) send_item(tick_item(), 1'b0, '0);
            item.operation = l.op;
            item.rx_byte   = l.fix_sum ? ~frame_sum : l.data;
            send_item(item, l.has_typed && (n == int'(l.count) - 1), l.typed);
         end
      end
      script.delete();
   endtask

   // ---------------------------------------------------------------------
   // Random traffic
   // ---------------------------------------------------------------------
   function automatic int gap_cap();
      return (ib_limit < 16'd59) ? int'(ib_limit) + 1 : 60;
   endfunction

   // Mostly complete frames with random content; some loose (ticks between
   // bytes), some broken (cut short, long gaps, bad checksum).
   task automatic random_frame();
      int style, stop_at, ticks;
      style   = $urandom_range(0, 99);
      stop_at = FRAME_BYTES;
      if (style >= 80 && $urandom_range(0, 1) == 1) stop_at = $urandom_range(1, FRAME_BYTES - 1);
      send_byte(sof_byte);
      for (int k = 1; k < stop_at; k++) begin
         ticks = 0;
         if (style >= 45 && $urandom_range(0, 99) < 20) ticks = $urandom_range(1, gap_cap());
         if (style >= 80 && $urandom_range(0, 99) < 10) ticks = gap_cap() + $urandom_range(0, 8);
         repeat (ticks) send_item(tick_item(), 1'b0, '0);
         if (k == FRAME_BYTES - 1 && $urandom_range(0, 99) < 90) send_byte(~frame_sum);
         else if ($urandom_range(0, 99) < 8) send_byte(sof_byte);
         else send_byte(8'($urandom));
      end
   endtask

   task automatic line_noise();
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 1) == 1) send_item(tick_item(), 1'b0, '0);
         else send_byte(8'($urandom));
         noise_items++;
      end
   endtask

   task automatic run_segment(input logic [15:0] ib, input logic [15:0] ft,
                              input logic [7:0] sof);
      int start_count;
      set_registers(ib, ft, sof);
      start_count = items_accepted - noise_items;
      while (items_accepted - noise_items - start_count < SEGMENT_ITEMS) begin
         if ($urandom_range(0, 99) < 20) line_noise();
         else random_frame();
      end
   endtask

   task automatic set_idling(input int sender, input int receiver);
      send_idle_pct  = sender;
      recv_stall_pct = receiver;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // registers must come up at their reset values
      verify_register(REG_INTERBYTE);
      verify_register(REG_FRAME_TO);
      verify_register(REG_START);
      // write to a hole in the map is dropped
      csr_write(UNMAPPED_ADDR, $urandom);
      verify_register(REG_INTERBYTE);
      verify_register(REG_FRAME_TO);
      verify_register(REG_START);

      // opening script under reset settings (gap 50, frame 300, start 0x7F)
      add_line(OP_TICK, 8'hFF, 3);                       // ticks while idle
      add_line(OP_BYTE, 8'h00, 2);                       // not a start byte
      add_line(OP_BYTE, 8'hFF, 1);
      add_line(OP_BYTE, START_RESET, 1);                 // zero body, bad sum
      add_line(OP_BYTE, 8'h00, 17, 0, 1'b0, 1'b1, CHECKSUM_REPORT);
      add_line(OP_BYTE, START_RESET, 1);                 // all-ones fields
      add_line(OP_BYTE, 8'hFF, 16);
      add_line(OP_BYTE, 8'h00, 1, 0, 1'b1, 1'b1, ALL_ONES_REPORT);
      add_line(OP_BYTE, START_RESET, 1);                 // all-zero fields, good sum
      add_line(OP_BYTE, 8'h00, 16);
      add_line(OP_BYTE, 8'h00, 1, 0, 1'b1, 1'b1, ALL_ZERO_REPORT);
      add_line(OP_BYTE, START_RESET, 1);                 // start byte as payload
      add_line(OP_BYTE, START_RESET, 16);
      add_line(OP_BYTE, 8'h00, 1, 0, 1'b1);
      add_line(OP_BYTE, START_RESET, 1);                 // gap of 51 kills the frame,
      add_line(OP_BYTE, 8'h11, 3);                       // the late start byte reopens
      add_line(OP_BYTE, START_RESET, 1, 51);
      add_line(OP_BYTE, 8'h22, 16);
      add_line(OP_BYTE, 8'h00, 1, 0, 1'b1);
      add_line(OP_BYTE, START_RESET, 1);                 // gaps of exactly 50 pass,
      add_line(OP_BYTE, 8'h33, 7, 50);                   // frame age 350 drops it
      add_line(OP_BYTE, 8'h44, 1);                       // idle again, ignored
      play_script();

      // random phases, two register settings each
      set_idling(0, 0);
      run_segment(16'd50, 16'd300, START_RESET);
      run_segment(16'hFFFF, 16'hFFFF, 8'hFF);
      set_idling(83, 0);
      run_segment(16'd0, 16'd0, 8'h00);
      run_segment(16'($urandom_range(0, 80)), 16'($urandom_range(0, 400)), 8'($urandom));
      set_idling(0, 83);
      run_segment(16'd1, 16'd2, 8'($urandom));
      run_segment(16'd20, 16'd120, 8'hA5);
      set_idling(15, 15);
      run_segment(16'($urandom_range(0, 60)), 16'($urandom_range(50, 350)), 8'($urandom));
      run_segment(16'd50, 16'd300, START_RESET);

      settle();
      if (frame_reports.size() != 0)
         note_error($sformatf("%0d reports never arrived", frame_reports.size()));
      $display("ran %0d request transactions (%0d noise), checked %0d frame reports,",
               items_accepted, noise_items, reports_seen);
      $display("%0d register writes over 8 settings and 4 idle/stall mixes, %0d mismatches",
               configs_written, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #(WATCHDOG_NS);
      $display("watchdog expired with %0d reports owed", frame_reports.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
